// ===== hdl/jitc_pkg.sv =====
// Shared types and constants of the joint impedance torque controller.
// Used by the top level, the checker and the per-joint state memory sizing.
// No dependencies.
package jitc_pkg;

   localparam int JOINTS = 7;
   localparam int ADDR_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_DATA_W  = 23;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] REQ_SAMPLE   = 2'd0;
   localparam logic [1:0] REQ_LOAD     = 2'd1;
   localparam logic [1:0] REQ_ACTIVATE = 2'd2;

   // Control modes.
   localparam logic [1:0] MODE_HOLDING  = 2'd0;
   localparam logic [1:0] MODE_TRACKING = 2'd1;
   localparam logic [1:0] MODE_FAULT    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TARGET_ALPHA   = 2'd0;
   localparam logic [1:0] CSR_VELOCITY_ALPHA = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_US     = 2'd2;
   localparam logic [1:0] CSR_MAX_ERROR      = 2'd3;

   localparam logic [16:0] TARGET_ALPHA_RST   = 17'd11259;
   localparam logic [16:0] VELOCITY_ALPHA_RST = 17'd64881;
   localparam logic [19:0] TIMEOUT_US_RST     = 20'd500000;
   localparam logic [22:0] MAX_ERROR_RST      = 23'd52429;

   localparam logic [16:0]        ALPHA_ONE       = 17'd65536;
   localparam logic signed [20:0] FUTURE_LIMIT_US = -21'sd10000;

   // Input item, last declared field in the lowest bits.
   typedef struct packed {
      logic [5:0]         pad;
      logic [15:0]        damping;
      logic [15:0]        stiffness;
      logic signed [20:0] target_age_us;
      logic               target_new;
      logic               target_valid;
      logic signed [23:0] target_position;
      logic signed [23:0] measured_velocity;
      logic signed [23:0] measured_position;
      logic [2:0]         joint_index;
   } req_data_type;

   // Result item, last declared field in the lowest bits.
   typedef struct packed {
      logic [1:0]         pad;
      logic [1:0]         mode;
      logic               fault;
      logic signed [31:0] torque;
      logic [2:0]         out_joint;
   } rsp_data_type;

   // One entry of the per-joint state memory.
   typedef struct packed {
      logic [15:0]        damping;
      logic [15:0]        stiffness;
      logic signed [23:0] filtered_velocity;
      logic signed [23:0] filtered_target;
      logic signed [23:0] hold_target;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Low-pass update x + round(p / 2^16), where p = alpha * (u - x).
   // The result lies between x and u, so it fits 24 bits.
   function automatic logic signed [23:0] jitc_filt(input logic signed [23:0] x,
                                                    input logic signed [43:0] p);
      logic signed [43:0] r;
      r = (p + 44'sd32768) >>> 16;
      return 24'(44'(x) + r);
   endfunction

   // Alphas above one are taken as one.
   function automatic logic [16:0] jitc_alpha_sat(input logic [16:0] a);
      return (a > ALPHA_ONE) ? ALPHA_ONE : a;
   endfunction

endpackage

// ===== hdl/joint_impedance_torque_control.sv =====
// Joint impedance torque controller. A tracking sample runs through every state, a holding
// sample skips the target filter, and load, activate and rejected items go from the read
// straight to the result, which waits while the output is stalled. Items go one at a time
// through the single shared 18x26 multiplier; a new one is taken once the last is registered.
// Synchronous active-high reset restores the configuration defaults, the holding mode and
// marks every joint entry as zero; no clearing pass is needed.
// Depends on jitc_pkg and jitc_ram.
module joint_impedance_torque_control (
   input  logic                              clock,
   input  logic                              reset,
   // Input items.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: joint_index, measured_position, measured_velocity, target_position,
   // target_valid, target_new, target_age_us, stiffness, damping, zero fill.
   input  logic [jitc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type.
   input  logic [1:0]                        req_tuser,
   // Result items.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: out_joint, torque, fault, mode, zero fill.
   output logic [jitc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [jitc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // The sequencer walks one item at a time through the memory read, the two filter
   // multiplies, the goal computation, the two gain multiplies, the torque sum and the
   // write-back. Because the next read is issued only after the write-back, accesses to
   // the same joint entry never overlap and no forwarding is needed.
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_READ   = 9'b000000010,
      S_FILT_T = 9'b000000100,
      S_FILT_V = 9'b000001000,
      S_GOAL   = 9'b000010000,
      S_MUL_K  = 9'b000100000,
      S_MUL_D  = 9'b001000000,
      S_SUM    = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [16:0] talpha_ff, talpha_in;
   logic [16:0] valpha_ff, valpha_in;
   logic [19:0] timeout_ff, timeout_in;
   logic [22:0] maxerr_ff, maxerr_in;
   logic [jitc_pkg::JOINTS-1:0] valid_ff, valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   jitc_pkg::req_data_type item_ff, item_in;
   logic [1:0]             kind_ff, kind_in;
   jitc_pkg::entry_type    ent_ff, ent_in;
   logic                   track_ff, track_in;
   logic                   wr_ff, wr_in;
   logic signed [24:0]     diff_ff, diff_in;
   logic signed [43:0]     prod_ff, prod_in;
   logic signed [43:0]     pk_ff, pk_in;
   logic signed [31:0]     torque_ff, torque_in;
   jitc_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        slot_free;
   logic [jitc_pkg::ADDR_W-1:0] item_addr;
   logic [jitc_pkg::ENTRY_W-1:0] ram_rd_data;
   logic                        ram_wr_en;

   logic signed [17:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [43:0] mul_p;

   jitc_pkg::req_data_type req_item;

   assign req_item  = jitc_pkg::req_data_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign item_addr = jitc_pkg::ADDR_W'(item_ff.joint_index);
   assign ram_wr_en = (state_ff == S_DONE) && slot_free && wr_ff;

   // Per-joint state: hold target, both filters and both gains in one entry.
   jitc_ram #(
      .WIDTH (jitc_pkg::ENTRY_W),
      .DEPTH (jitc_pkg::JOINTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (item_addr),
      .wr_data (ent_ff),
      .rd_en   (accept),
      .rd_addr (jitc_pkg::ADDR_W'(req_item.joint_index)),
      .rd_data (ram_rd_data)
   );

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_FILT_T: begin
            mul_a = $signed({1'b0, jitc_pkg::jitc_alpha_sat(talpha_ff)});
            mul_b = 26'(item_ff.target_position) - 26'(ent_ff.filtered_target);
         end
         S_FILT_V: begin
            mul_a = $signed({1'b0, jitc_pkg::jitc_alpha_sat(valpha_ff)});
            mul_b = 26'(item_ff.measured_velocity) - 26'(ent_ff.filtered_velocity);
         end
         S_MUL_K: begin
            mul_a = $signed({2'b00, ent_ff.stiffness});
            mul_b = 26'(diff_ff);
         end
         S_MUL_D: begin
            mul_a = $signed({2'b00, ent_ff.damping});
            mul_b = 26'(ent_ff.filtered_velocity);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Sequencer and datapath next-state logic.
   always_comb begin
      logic               in_range;
      logic               fresh;
      logic               bad;
      logic signed [24:0] err;
      logic signed [24:0] lim;
      logic signed [44:0] acc;
      logic signed [44:0] rnd;

      state_in    = state_ff;
      mode_in     = mode_ff;
      talpha_in   = talpha_ff;
      valpha_in   = valpha_ff;
      timeout_in  = timeout_ff;
      maxerr_in   = maxerr_ff;
      valid_in    = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      item_in     = item_ff;
      kind_in     = kind_ff;
      ent_in      = ent_ff;
      track_in    = track_ff;
      wr_in       = wr_ff;
      diff_in     = diff_ff;
      prod_in     = prod_ff;
      pk_in       = pk_ff;
      torque_in   = torque_ff;
      rsp_data_in = rsp_data_ff;

      in_range = 32'(item_ff.joint_index) < jitc_pkg::JOINTS;
      fresh    = item_ff.target_valid && item_ff.target_new;
      bad      = !item_ff.target_valid
                 || (item_ff.target_age_us < jitc_pkg::FUTURE_LIMIT_US)
                 || ($signed({item_ff.target_age_us[20], item_ff.target_age_us})
                     > $signed({2'b00, timeout_ff}));
      err = 25'(ent_ff.filtered_target) - 25'(item_ff.measured_position);
      lim = $signed({2'b00, maxerr_ff});
      acc = 45'(pk_ff) - 45'(prod_ff);
      rnd = (acc + 45'sd8) >>> 4;

      if (csr_we) begin
         unique case (csr_index)
            jitc_pkg::CSR_TARGET_ALPHA:   talpha_in  = csr_wdata[16:0];
            jitc_pkg::CSR_VELOCITY_ALPHA: valpha_in  = csr_wdata[16:0];
            jitc_pkg::CSR_TIMEOUT_US:     timeout_in = csr_wdata[19:0];
            jitc_pkg::CSR_MAX_ERROR:      maxerr_in  = csr_wdata[22:0];
            default:                      maxerr_in  = maxerr_ff;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in  = req_item;
               kind_in  = req_tuser;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // An entry never written since reset reads as zero.
            ent_in    = valid_ff[item_addr] ? jitc_pkg::entry_type'(ram_rd_data) : '0;
            torque_in = '0;
            wr_in     = 1'b0;
            track_in  = 1'b0;
            state_in  = S_DONE;
            if (in_range) begin
               case (kind_ff)
                  jitc_pkg::REQ_LOAD: begin
                     ent_in.stiffness = item_ff.stiffness;
                     ent_in.damping   = item_ff.damping;
                     wr_in            = 1'b1;
                  end
                  jitc_pkg::REQ_ACTIVATE: begin
                     ent_in.hold_target       = item_ff.measured_position;
                     ent_in.filtered_target   = item_ff.measured_position;
                     ent_in.filtered_velocity = '0;
                     mode_in                  = jitc_pkg::MODE_HOLDING;
                     wr_in                    = 1'b1;
                  end
                  jitc_pkg::REQ_SAMPLE: begin
                     if (mode_ff != jitc_pkg::MODE_FAULT) begin
                        if (fresh || mode_ff == jitc_pkg::MODE_TRACKING) begin
                           if (bad) begin
                              mode_in = jitc_pkg::MODE_FAULT;
                           end else begin
                              if (fresh) begin
                                 mode_in = jitc_pkg::MODE_TRACKING;
                              end
                              track_in = 1'b1;
                              state_in = S_FILT_T;
                           end
                        end else begin
                           state_in = S_FILT_V;
                        end
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FILT_T: begin
            prod_in  = mul_p;
            state_in = S_FILT_V;
         end
         S_FILT_V: begin
            if (track_ff) begin
               ent_in.filtered_target = jitc_pkg::jitc_filt(ent_ff.filtered_target, prod_ff);
            end
            prod_in  = mul_p;
            state_in = S_GOAL;
         end
         S_GOAL: begin
            ent_in.filtered_velocity = jitc_pkg::jitc_filt(ent_ff.filtered_velocity, prod_ff);
            if (track_ff) begin
               // Goal minus position is the clamped tracking error.
               if (err > lim) begin
                  diff_in = lim;
               end else if (err < -lim) begin
                  diff_in = -lim;
               end else begin
                  diff_in = err;
               end
            end else begin
               diff_in = 25'(ent_ff.hold_target) - 25'(item_ff.measured_position);
            end
            state_in = S_MUL_K;
         end
         S_MUL_K: begin
            prod_in  = mul_p;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            pk_in    = prod_ff;
            prod_in  = mul_p;
            state_in = S_SUM;
         end
         S_SUM: begin
            if (rnd > 45'sd2147483647) begin
               torque_in = 32'sh7FFFFFFF;
            end else if (rnd < -45'sd2147483648) begin
               torque_in = 32'sh80000000;
            end else begin
               torque_in = rnd[31:0];
            end
            wr_in    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.pad       = '0;
               rsp_data_in.out_joint = item_ff.joint_index;
               rsp_data_in.torque    = torque_ff;
               rsp_data_in.mode      = mode_ff;
               rsp_data_in.fault     = (mode_ff == jitc_pkg::MODE_FAULT);
               if (wr_ff) begin
                  valid_in[item_addr] = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= jitc_pkg::MODE_HOLDING;
         talpha_ff    <= jitc_pkg::TARGET_ALPHA_RST;
         valpha_ff    <= jitc_pkg::VELOCITY_ALPHA_RST;
         timeout_ff   <= jitc_pkg::TIMEOUT_US_RST;
         maxerr_ff    <= jitc_pkg::MAX_ERROR_RST;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         talpha_ff    <= talpha_in;
         valpha_ff    <= valpha_in;
         timeout_ff   <= timeout_in;
         maxerr_ff    <= maxerr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      kind_ff     <= kind_in;
      ent_ff      <= ent_in;
      track_ff    <= track_in;
      wr_ff       <= wr_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      pk_ff       <= pk_in;
      torque_ff   <= torque_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/jitc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module jitc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/jitc_checker.sv =====
// Port-level assertions for the joint impedance torque controller, bound to the top level.
// Depends on jitc_pkg.
module jitc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [jitc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   jitc_pkg::rsp_data_type rsp;

   assign rsp = jitc_pkg::rsp_data_type'(rsp_tdata);

   // One item at a time: after an accept the input side closes.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item was in work");

   // The fault flag mirrors the latched fault mode.
   a_fault_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.fault == (rsp.mode == jitc_pkg::MODE_FAULT)))
      else $error("fault flag disagrees with mode");

   // No torque is commanded while faulted.
   a_fault_torque: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.fault |-> rsp.torque == 32'sd0)
      else $error("nonzero torque in fault mode");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind joint_impedance_torque_control jitc_checker u_jitc_checker (.*);
